FILE: src/sorted_prefix_budget_query_top_defines.svh
// Assertion macros used by the checker file.
`ifndef SORTED_PREFIX_BUDGET_QUERY_TOP_DEFINES_SVH
`define SORTED_PREFIX_BUDGET_QUERY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SPBQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spbq assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SPBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spbq assertion failed");

`endif

FILE: src/spbq_pkg.sv
package spbq_pkg;

    // Field widths
    localparam int VALUE_W    = 32;
    localparam int BUDGET_W   = 42;
    localparam int COUNT_W    = 11;
    localparam int IN_TDATA_W  = 112;  // 32 + 32 + 42 = 106, padded to bytes
    localparam int OUT_TDATA_W = 16;   // 11, padded to bytes

    // Operation codes carried in s_axis_tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Result status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_SWAIT,
        S_TWAIT,
        S_SHIFT,
        S_WDRAIN,
        S_FIN
    } t_state;

endpackage

FILE: src/sorted_prefix_budget_query_top.sv
// Steps: an insert runs a binary search for its slot, then shifts the entries above it up;
//   a query searches the values, then the prefix sums. Insert into a full store: no search.
// Throughput: one item at a time, taken only once the last result is in the output register;
//   the read-modify-write pass over the value and prefix-sum memories (one entry a cycle)
//   sets the insert time.
// Reset (synchronous, active low) empties the store; memory contents stay as they were
//   and only entries below the stored count are used.
module sorted_prefix_budget_query_top #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] item_value, [63:32] price_limit, [105:64] budget, rest zero
    input  logic [spbq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] op
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [10:0] answer_count, rest zero
    output logic [spbq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] status
    output logic                              m_axis_tuser
);
    import spbq_pkg::*;

    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int SUMW = ($clog2(MAX_ITEMS) + VALUE_W > BUDGET_W) ?
                          $clog2(MAX_ITEMS) + VALUE_W : BUDGET_W;

    // Storage
    logic [VALUE_W-1:0] mem_val [MAX_ITEMS];
    logic [SUMW-1:0]    mem_sum [MAX_ITEMS];
    logic [VALUE_W-1:0] r_rd_val;
    logic [SUMW-1:0]    r_rd_sum;
    logic [AW-1:0]      w_ra;
    logic [VALUE_W-1:0] w_wval;
    logic [SUMW-1:0]    w_wsum;

    t_state r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic                r_phase, n_phase;
    logic                r_op, n_op;
    logic [VALUE_W-1:0]  r_key, n_key;
    logic [BUDGET_W-1:0] r_budget, n_budget;
    logic [SUMW-1:0]     r_top, n_top;
    logic [CW-1:0]       r_pos, n_pos, r_ptr, n_ptr;
    logic                r_wv, n_wv, r_wlast, n_wlast;
    logic [AW-1:0]       r_wa, n_wa;
    logic [CW-1:0]       r_res, n_res;
    logic                r_res_st, n_res_st;
    logic                r_ovalid, n_ovalid;
    logic [CW-1:0]       r_ocnt, n_ocnt;
    logic                r_ost, n_ost;

    logic                w_accept, w_full, w_go_right, w_load;
    logic [CW:0]         w_midsum;
    logic [CW-1:0]       w_mid, w_midm1, w_lom1, w_ptrm1;
    logic [SUMW-1:0]     w_pb;
    logic [CW+COUNT_W-1:0] w_opad;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_full   = (r_cnt >= CW'(MAX_ITEMS));
    assign w_midsum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_midsum[CW:1];
    assign w_midm1  = w_mid - CW'(1);
    assign w_lom1   = r_lo - CW'(1);
    assign w_ptrm1  = r_ptr - CW'(1);
    assign w_load   = (r_state == S_FIN) && (!r_ovalid || m_axis_tready);

    // Compare step of both binary searches
    assign w_pb = (r_mid == '0) ? '0 : r_rd_sum;
    always_comb begin
        if (r_phase) begin
            w_go_right = !((r_top - w_pb) <= SUMW'(r_budget));
        end else begin
            w_go_right = (r_rd_val <= r_key);
        end
    end

    // Write data of the shift pass
    always_comb begin
        if (r_wlast) begin
            w_wval = r_key;
            w_wsum = ((r_wa == '0) ? '0 : r_rd_sum) + SUMW'(r_key);
        end else begin
            w_wval = r_rd_val;
            w_wsum = r_rd_sum + SUMW'(r_key);
        end
    end

    // Memories, one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (r_wv) begin
            mem_val[r_wa] <= w_wval;
            mem_sum[r_wa] <= w_wsum;
        end
        r_rd_val <= mem_val[w_ra];
        r_rd_sum <= mem_sum[w_ra];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (s_axis_tuser == OP_INSERT && w_full) ? S_FIN : S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_state = S_SWAIT;
                end else if (r_phase) begin
                    n_state = S_FIN;
                end else if (r_op == OP_INSERT) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = (r_lo == '0) ? S_FIN : S_TWAIT;
                end
            end
            S_SWAIT:  n_state = S_SRCH;
            S_TWAIT:  n_state = S_SRCH;
            S_SHIFT:  n_state = (r_ptr == r_pos) ? S_WDRAIN : S_SHIFT;
            S_WDRAIN: n_state = S_FIN;
            S_FIN:    n_state = w_load ? S_IDLE : S_FIN;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_cnt    = r_cnt;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_phase  = r_phase;
        n_op     = r_op;
        n_key    = r_key;
        n_budget = r_budget;
        n_top    = r_top;
        n_pos    = r_pos;
        n_ptr    = r_ptr;
        n_wv     = 1'b0;
        n_wlast  = r_wlast;
        n_wa     = r_wa;
        n_res    = r_res;
        n_res_st = r_res_st;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_ocnt   = r_ocnt;
        n_ost    = r_ost;
        w_ra     = w_mid[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = s_axis_tuser;
                    n_key    = (s_axis_tuser == OP_QUERY) ? s_axis_tdata[63:32]
                                                          : s_axis_tdata[31:0];
                    n_budget = s_axis_tdata[105:64];
                    n_lo     = '0;
                    n_hi     = r_cnt;
                    n_phase  = 1'b0;
                    n_res    = r_cnt;
                    n_res_st = (s_axis_tuser == OP_INSERT && w_full) ? ST_FULL : ST_OK;
                end
            end
            S_SRCH: begin
                n_mid = w_mid;
                w_ra  = r_phase ? w_midm1[AW-1:0] : w_mid[AW-1:0];
                if (r_lo >= r_hi) begin
                    if (r_phase) begin
                        n_res = r_pos - r_lo;
                    end else if (r_op == OP_INSERT) begin
                        n_pos = r_lo;
                        n_ptr = r_cnt;
                    end else begin
                        n_pos = r_lo;
                        n_res = '0;
                        w_ra  = w_lom1[AW-1:0];
                    end
                end
            end
            S_SWAIT: begin
                if (w_go_right) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
            end
            S_TWAIT: begin
                n_top   = r_rd_sum;
                n_lo    = '0;
                n_hi    = r_pos;
                n_phase = 1'b1;
            end
            S_SHIFT: begin
                // read the entry below, write it one slot up next cycle
                w_ra    = w_ptrm1[AW-1:0];
                n_wv    = 1'b1;
                n_wa    = r_ptr[AW-1:0];
                n_wlast = (r_ptr == r_pos);
                n_ptr   = w_ptrm1;
            end
            S_WDRAIN: begin
                n_cnt = r_cnt + CW'(1);
                n_res = r_cnt + CW'(1);
            end
            S_FIN: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_ocnt   = r_res;
                    n_ost    = r_res_st;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_wv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_wv     <= n_wv;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_phase  <= n_phase;
        r_op     <= n_op;
        r_key    <= n_key;
        r_budget <= n_budget;
        r_top    <= n_top;
        r_pos    <= n_pos;
        r_ptr    <= n_ptr;
        r_wlast  <= n_wlast;
        r_wa     <= n_wa;
        r_res    <= n_res;
        r_res_st <= n_res_st;
        r_ocnt   <= n_ocnt;
        r_ost    <= n_ost;
    end

    // Ports
    assign w_opad        = {{COUNT_W{1'b0}}, r_ocnt};
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-COUNT_W){1'b0}}, w_opad[COUNT_W-1:0]};
    assign m_axis_tuser  = r_ost;

endmodule

FILE: src/spbq_checker.sv
`include "sorted_prefix_budget_query_top_defines.svh"

module spbq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [spbq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tuser
);
    import spbq_pkg::*;

    // A stalled result stays offered and unchanged
    `SPBQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `SPBQ_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // One item in work at a time
    `SPBQ_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A dropped insert only happens on a non-empty store
    `SPBQ_ASSERT_NOW(a_full_count, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == ST_FULL, m_axis_tdata[COUNT_W-1:0] != '0)

endmodule

bind sorted_prefix_budget_query_top spbq_checker u_spbq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import spbq_pkg::*;

    localparam int CAP = 1024;
    localparam longint CYCLE_LIMIT = 64'd4000000;

    typedef struct packed {
        logic                op;
        logic [VALUE_W-1:0]  value;
        logic [VALUE_W-1:0]  limit;
        logic [BUDGET_W-1:0] budget;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               status;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    sorted_prefix_budget_query_top #(.MAX_ITEMS(CAP)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Shadow store: ascending values and the live count
    logic [VALUE_W-1:0] shadow_vals [CAP];
    int unsigned        shadow_count;

    t_item   pending_items [$];
    t_result expected_results [$];
    int      errors;
    longint  cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_send;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Predict the result of one accepted item and update the shadow store
    function automatic t_result predict_budget_answer(t_item it);
        t_result r;
        int unsigned eligible;
        int unsigned pos;
        int unsigned taken;
        logic [63:0] sum;
        r.status = ST_OK;
        if (it.op == OP_INSERT) begin
            if (shadow_count >= CAP) begin
                r.count = shadow_count[COUNT_W-1:0];
                r.status = ST_FULL;
                return r;
            end
            pos = 0;
            while (pos < shadow_count && shadow_vals[pos] <= it.value) pos++;
            for (int i = shadow_count; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
            shadow_vals[pos] = it.value;
            shadow_count++;
            r.count = shadow_count[COUNT_W-1:0];
            return r;
        end
        eligible = 0;
        while (eligible < shadow_count && shadow_vals[eligible] <= it.limit) eligible++;
        // take the largest eligible values while they fit the budget
        taken = 0;
        sum = 0;
        while (taken < eligible) begin
            sum += shadow_vals[eligible - taken - 1];
            if (sum > {22'd0, it.budget}) break;
            taken++;
        end
        r.count = taken[COUNT_W-1:0];
        return r;
    endfunction

    function automatic t_item make_insert(logic [VALUE_W-1:0] v);
        t_item it;
        it.op = OP_INSERT;
        it.value = v;
        it.limit = $urandom;
        it.budget = BUDGET_W'({$urandom, $urandom});
        return it;
    endfunction

    function automatic t_item make_query(logic [VALUE_W-1:0] p, logic [BUDGET_W-1:0] s);
        t_item it;
        it.op = OP_QUERY;
        it.value = $urandom;
        it.limit = p;
        it.budget = s;
        return it;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [BUDGET_W-1:0] rand_budget();
        logic [BUDGET_W-1:0] b;
        b = BUDGET_W'({$urandom, $urandom});
        case ($urandom_range(0, 4))
            0: return '0;
            1: return {BUDGET_W{1'b1}};
            2: return b >> $urandom_range(0, BUDGET_W - 1);
            3: return BUDGET_W'($urandom_range(0, 5000));
            default: return b;
        endcase
    endfunction

    // Sample on the falling edge so the queues and the driver have settled
    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
            @(negedge i_clk);
    endtask

    // Driver: one item at a time from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_budget_answer(
                    t_item'{s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                            s_axis_tdata[105:64]}));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() != 0 && !hold_send
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_item it;
                    it = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= it.op;
                    s_axis_tdata <= {6'd0, it.budget, it.limit, it.value};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result count=%0d status=%0d",
                           m_axis_tdata[COUNT_W-1:0], m_axis_tuser);
                    errors++;
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (m_axis_tdata[COUNT_W-1:0] !== e.count) begin
                        $error("answer_count expected %0d actual %0d", e.count,
                               m_axis_tdata[COUNT_W-1:0]);
                        errors++;
                    end
                    if (m_axis_tuser !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, m_axis_tuser);
                        errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_send = 1'b0;
        shadow_count = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, extremes, equal values, zeros, everything fits
        pending_items.push_back(make_query(32'hFFFF_FFFF, {BUDGET_W{1'b1}}));
        pending_items.push_back(make_insert(32'hFFFF_FFFF));
        pending_items.push_back(make_insert(32'd0));
        pending_items.push_back(make_insert(32'd0));
        pending_items.push_back(make_insert(32'd5));
        pending_items.push_back(make_insert(32'd5));
        pending_items.push_back(make_insert(32'd7));
        pending_items.push_back(make_insert(32'hFFFF_FFFF));
        pending_items.push_back(make_query(32'd0, '0));
        pending_items.push_back(make_query(32'd4, '0));
        pending_items.push_back(make_query(32'd7, 42'd12));
        pending_items.push_back(make_query(32'd7, 42'd11));
        pending_items.push_back(make_query(32'd7, 42'd17));
        pending_items.push_back(make_query(32'hFFFF_FFFE, {BUDGET_W{1'b1}}));
        pending_items.push_back(make_query(32'hFFFF_FFFF, {BUDGET_W{1'b1}}));
        pending_items.push_back(make_query(32'hFFFF_FFFF, 42'hFFFF_FFFE));
        pending_items.push_back(make_query(32'hFFFF_FFFF, '0));
        wait_drained();

        // Pause until every result is in, then random phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int n = 0; n < 105; n++) begin
                if ($urandom_range(0, 1) == 0)
                    pending_items.push_back(make_insert(rand_value()));
                else
                    pending_items.push_back(make_query(rand_value(), rand_budget()));
            end
            wait_drained();
        end

        // Closing queries on the final store, then one more insert
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int n = 0; n < 12; n++)
            pending_items.push_back(make_query(rand_value(), rand_budget()));
        pending_items.push_back(make_query(32'hFFFF_FFFF, {BUDGET_W{1'b1}}));
        pending_items.push_back(make_insert(32'd0));
        wait_drained();

        repeat (CAP + 100) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
